// File: hw/rtl/lrukv_pkg.sv
package lrukv_pkg;

    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Wide enough for any capacity and for a fill of up to 256 entries.
    localparam int CALC_W = 9;

    localparam logic [CAP_W-1:0]  CAP_RESET = 5'd16;
    localparam logic [DATA_W-1:0] MISS_DATA = 32'hFFFF_FFFF;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } t_state;

endpackage

// File: hw/rtl/lru_key_value_cache_core.sv
// Fully associative key-value cache with least-recently-used replacement.
//
// Items: an item (i_op, i_key, i_data_in) is taken at a rising edge where start is
// high and busy is low. i_op selects a get (lookup) or a put (insert or update).
// Each item produces exactly one result on o_found, o_data_out, o_evicted and
// o_evicted_key, shown for one cycle while o_result_valid is high. The receiver
// cannot stall; the result is gone after that cycle.
// Configuration: capacity_in_use is written through i_cfg_valid / i_cfg_data. The
// user must write it only while the block is idle; the block does not enforce this.
// o_cfg_ready is always high.
// Sequence: every item first sweeps the entry memory, then passes through a
// decision state. A get that misses then shows its result. Every other item runs a
// second sweep over the memory for the age update and write-back. busy falls in
// the result cycle, so the next item can be taken there. The sweeps over the
// entry memory set the time an item takes.
// Reset: all entries become invalid, the fill is zero and the capacity is 16.
// No clearing pass is needed.
module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_op,
    input  logic signed [lrukv_pkg::KEY_W-1:0]    i_key,
    input  logic signed [lrukv_pkg::DATA_W-1:0]   i_data_in,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic        [lrukv_pkg::CAP_W-1:0]    i_cfg_data,
    output logic                                  o_result_valid,
    output logic                                  o_found,
    output logic signed [lrukv_pkg::DATA_W-1:0]   o_data_out,
    output logic                                  o_evicted,
    output logic signed [lrukv_pkg::KEY_W-1:0]    o_evicted_key
);
    import lrukv_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int AW = IW;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0]     LAST_IDX = CW'(MAX_ENTRIES);
    localparam logic [CALC_W-1:0] MAX_CAP  = CALC_W'(MAX_ENTRIES);

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] value;
        logic [AW-1:0]     age;
    } t_entry;

    // Entry memory: one write port, one registered read port.
    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;
    logic   mem_we;
    logic   [IW-1:0] mem_waddr;
    t_entry mem_wdata;
    logic   [IW-1:0] mem_raddr;
    logic   issue;

    // Control state.
    t_state r_state, n_state;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_rd_pend, n_rd_pend;
    logic                   r_rd_v, n_rd_v;
    logic                   r_hit, n_hit;
    logic                   r_free_found, n_free_found;
    logic                   r_old_found, n_old_found;
    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0]          r_count, n_count;
    logic [CAP_W-1:0]       r_capacity, n_capacity;

    // Item payload and sweep results.
    logic              r_op, n_op;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [DATA_W-1:0] r_data, n_data;
    logic [IW-1:0]     r_rd_slot, n_rd_slot;
    logic [IW-1:0]     r_hit_slot, n_hit_slot;
    logic [AW-1:0]     r_hit_age, n_hit_age;
    logic [DATA_W-1:0] r_hit_val, n_hit_val;
    logic [IW-1:0]     r_free_slot, n_free_slot;
    logic [IW-1:0]     r_old_slot, n_old_slot;
    logic [AW-1:0]     r_old_age, n_old_age;
    logic [KEY_W-1:0]  r_old_key, n_old_key;
    logic [IW-1:0]     r_tgt, n_tgt;
    logic              r_insert, n_insert;
    logic [AW-1:0]     r_touch_age, n_touch_age;
    logic [DATA_W-1:0] r_new_val, n_new_val;
    logic              r_found, n_found;
    logic [DATA_W-1:0] r_dout, n_dout;
    logic              r_ev, n_ev;
    logic [KEY_W-1:0]  r_evk, n_evk;

    logic [CALC_W-1:0] cap_eff;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    always_comb begin
        if (r_capacity == '0) begin
            cap_eff = CALC_W'(1);
        end else if (CALC_W'(r_capacity) > MAX_CAP) begin
            cap_eff = MAX_CAP;
        end else begin
            cap_eff = CALC_W'(r_capacity);
        end
    end

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE) && (r_state != ST_DONE);
    assign o_cfg_ready = 1'b1;
    assign issue       = ((r_state == ST_SCAN) || (r_state == ST_UPDATE)) && (r_idx != LAST_IDX);
    assign mem_raddr   = issue ? r_idx[IW-1:0] : '0;

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_rd_pend    = issue;
        n_rd_v       = issue ? r_valid[mem_raddr] : 1'b0;
        n_rd_slot    = mem_raddr;
        n_hit        = r_hit;
        n_free_found = r_free_found;
        n_old_found  = r_old_found;
        n_valid      = r_valid;
        n_count      = r_count;
        n_capacity   = r_capacity;
        n_op         = r_op;
        n_key        = r_key;
        n_data       = r_data;
        n_hit_slot   = r_hit_slot;
        n_hit_age    = r_hit_age;
        n_hit_val    = r_hit_val;
        n_free_slot  = r_free_slot;
        n_old_slot   = r_old_slot;
        n_old_age    = r_old_age;
        n_old_key    = r_old_key;
        n_tgt        = r_tgt;
        n_insert     = r_insert;
        n_touch_age  = r_touch_age;
        n_new_val    = r_new_val;
        n_found      = r_found;
        n_dout       = r_dout;
        n_ev         = r_ev;
        n_evk        = r_evk;
        mem_we       = 1'b0;
        mem_waddr    = r_rd_slot;
        mem_wdata    = r_rd_data;

        if (i_cfg_valid) begin
            n_capacity = i_cfg_data;
        end

        if (accept) begin
            n_state      = ST_SCAN;
            n_idx        = '0;
            n_op         = i_op;
            n_key        = i_key;
            n_data       = i_data_in;
            n_hit        = 1'b0;
            n_free_found = 1'b0;
            n_old_found  = 1'b0;
        end

        if (issue) begin
            n_idx = r_idx + CW'(1);
        end

        case (r_state)
            ST_IDLE: begin
            end
            ST_SCAN: begin
                if (r_rd_pend) begin
                    if (r_rd_v) begin
                        if (!r_hit && (r_rd_data.key == r_key)) begin
                            n_hit      = 1'b1;
                            n_hit_slot = r_rd_slot;
                            n_hit_age  = r_rd_data.age;
                            n_hit_val  = r_rd_data.value;
                        end
                        // The first entry with the highest age is the eviction candidate.
                        if (!r_old_found || (r_rd_data.age > r_old_age)) begin
                            n_old_found = 1'b1;
                            n_old_slot  = r_rd_slot;
                            n_old_age   = r_rd_data.age;
                            n_old_key   = r_rd_data.key;
                        end
                    end else if (!r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_slot  = r_rd_slot;
                    end
                end
                if ((r_idx == LAST_IDX) && !r_rd_pend) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_found     = r_hit;
                n_dout      = '0;
                n_ev        = 1'b0;
                n_evk       = '0;
                n_insert    = 1'b0;
                n_tgt       = r_hit_slot;
                n_touch_age = r_hit_age;
                n_new_val   = r_data;
                n_idx       = '0;
                n_state     = ST_UPDATE;
                if (r_op == OP_GET) begin
                    n_new_val = r_hit_val;
                    if (r_hit) begin
                        n_dout = r_hit_val;
                    end else begin
                        n_dout  = MISS_DATA;
                        n_state = ST_DONE;
                    end
                end else if (!r_hit) begin
                    n_insert = 1'b1;
                    if (CALC_W'(r_count) < cap_eff) begin
                        n_tgt              = r_free_slot;
                        n_valid[r_free_slot] = 1'b1;
                        n_count            = r_count + CW'(1);
                    end else begin
                        n_tgt = r_old_slot;
                        n_ev  = 1'b1;
                        n_evk = r_old_key;
                    end
                end
            end
            ST_UPDATE: begin
                if (r_rd_pend) begin
                    if (r_rd_slot == r_tgt) begin
                        mem_we          = 1'b1;
                        mem_wdata.key   = r_key;
                        mem_wdata.value = r_new_val;
                        mem_wdata.age   = '0;
                    end else if (r_rd_v) begin
                        mem_we = 1'b1;
                        if (r_insert || (r_rd_data.age < r_touch_age)) begin
                            mem_wdata.age = r_rd_data.age + AW'(1);
                        end
                    end
                end
                if ((r_idx == LAST_IDX) && !r_rd_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!accept) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_idx        <= '0;
            r_rd_pend    <= 1'b0;
            r_rd_v       <= 1'b0;
            r_hit        <= 1'b0;
            r_free_found <= 1'b0;
            r_old_found  <= 1'b0;
            r_valid      <= '0;
            r_count      <= '0;
            r_capacity   <= CAP_RESET;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_rd_pend    <= n_rd_pend;
            r_rd_v       <= n_rd_v;
            r_hit        <= n_hit;
            r_free_found <= n_free_found;
            r_old_found  <= n_old_found;
            r_valid      <= n_valid;
            r_count      <= n_count;
            r_capacity   <= n_capacity;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_key       <= n_key;
        r_data      <= n_data;
        r_rd_slot   <= n_rd_slot;
        r_hit_slot  <= n_hit_slot;
        r_hit_age   <= n_hit_age;
        r_hit_val   <= n_hit_val;
        r_free_slot <= n_free_slot;
        r_old_slot  <= n_old_slot;
        r_old_age   <= n_old_age;
        r_old_key   <= n_old_key;
        r_tgt       <= n_tgt;
        r_insert    <= n_insert;
        r_touch_age <= n_touch_age;
        r_new_val   <= n_new_val;
        r_found     <= n_found;
        r_dout      <= n_dout;
        r_ev        <= n_ev;
        r_evk       <= n_evk;
    end

    assign o_result_valid = (r_state == ST_DONE);
    assign o_found        = r_found;
    assign o_data_out     = r_dout;
    assign o_evicted      = r_ev;
    assign o_evicted_key  = r_evk;

    // The fill count always matches the number of valid entries.
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CW'($countones(r_valid)) == r_count)
        else $error("fill count differs from valid entries");

    // An eviction only happens on a put of a key that was not present.
    a_evict_only_on_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_evicted |-> (r_op == OP_PUT) && !o_found)
        else $error("eviction reported on a hit or a get");

    // A get that misses returns all ones.
    a_get_miss_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (r_op == OP_GET) && !o_found |-> r_dout == MISS_DATA)
        else $error("get miss returned wrong data");

    // An accepted item keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_result_valid)
        else $error("block not busy after taking an item");

endmodule
